FILE: src/fpra_pkg.sv
// Shared types and constants for the fixed-point rounding ALU.
// No dependencies; used by every module in src.
package fpra_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int DATA_W            = 64;
    localparam int NUM_W             = 2 * DATA_W;
    localparam int DIV_STEPS         = 2;
    localparam int DIV_STAGES        = NUM_W / DIV_STEPS;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_RND  = 3'd4;
    localparam logic [2:0] OP_ITOF = 3'd5;

    // One transaction as it moves through the restoring divider chain.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [DATA_W-1:0] res;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] q;
    } t_div;

endpackage

FILE: src/fpra_pre.sv
// Front stages: input register, magnitudes, split multiply, rounding and
// divider setup. Depends on fpra_pkg.
module fpra_pre #(
    parameter int FRACTION_BITS = fpra_pkg::FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0]                 i_operation,
    input  logic [fpra_pkg::DATA_W-1:0] i_operand_a,
    input  logic [fpra_pkg::DATA_W-1:0] i_operand_b,
    output fpra_pkg::t_div             o_div
);
    import fpra_pkg::*;

    localparam logic [DATA_W-1:0] HALF = DATA_W'(1) << (FRACTION_BITS - 1);

    // S1
    logic              r1_valid;
    logic [2:0]        r1_op;
    logic [DATA_W-1:0] r1_a, r1_b;
    // S2
    logic              r2_valid, r2_neg, r2_sa;
    logic [2:0]        r2_op;
    logic [DATA_W-1:0] r2_ma, r2_mb, r2_addsub;
    logic [DATA_W-1:0] n2_ma, n2_mb;
    // S3
    logic              r3_valid, r3_neg, r3_rneg;
    logic [2:0]        r3_op;
    logic [DATA_W-1:0] r3_p00, r3_p01, r3_p10, r3_p11, r3_mag, r3_d;
    logic [NUM_W-1:0]  r3_num;
    logic [DATA_W-1:0] n3_mag;
    logic              n3_rneg;
    // S4
    logic              r4_valid, r4_neg, r4_rneg;
    logic [2:0]        r4_op;
    logic [NUM_W-1:0]  r4_prod, r4_num;
    logic [DATA_W-1:0] r4_mag, r4_d;
    // S5
    t_div              r5, n5;
    logic [DATA_W-1:0] n5_mag;
    logic              n5_neg;

    assign n2_ma = r1_a[DATA_W-1] ? (~r1_a + DATA_W'(1)) : r1_a;
    assign n2_mb = r1_b[DATA_W-1] ? (~r1_b + DATA_W'(1)) : r1_b;

    always_comb begin
        n3_mag  = '0;
        n3_rneg = 1'b0;
        case (r2_op)
            OP_ADD, OP_SUB: begin
                n3_mag = r2_addsub;
            end
            OP_RND: begin
                n3_mag  = (r2_ma + HALF) >> FRACTION_BITS;
                n3_rneg = r2_sa;
            end
            OP_ITOF: begin
                n3_mag  = r2_ma << FRACTION_BITS;
                n3_rneg = r2_sa;
            end
            OP_MUL: begin
                n3_rneg = r2_neg;
            end
            default: begin
                n3_mag = '0;
            end
        endcase
    end

    always_comb begin
        logic [NUM_W-1:0] shifted;
        shifted = r4_prod >> FRACTION_BITS;
        n5_mag  = (r4_op == OP_MUL) ? shifted[DATA_W-1:0] : r4_mag;
        n5_neg  = r4_rneg;
        n5.valid  = r4_valid;
        n5.is_div = (r4_op == OP_DIV);
        n5.neg    = r4_neg;
        n5.dz     = (r4_op == OP_DIV) && (r4_d == '0);
        n5.res    = n5_neg ? (~n5_mag + DATA_W'(1)) : n5_mag;
        n5.num    = r4_num;
        n5.d      = r4_d;
        n5.rem    = '0;
        n5.q      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5       <= n5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op <= i_operation;
            r1_a  <= i_operand_a;
            r1_b  <= i_operand_b;

            r2_op     <= r1_op;
            r2_ma     <= n2_ma;
            r2_mb     <= n2_mb;
            r2_neg    <= r1_a[DATA_W-1] ^ r1_b[DATA_W-1];
            r2_sa     <= r1_a[DATA_W-1];
            r2_addsub <= (r1_op == OP_SUB) ? (r1_a - r1_b) : (r1_a + r1_b);

            r3_op   <= r2_op;
            r3_neg  <= r2_neg;
            r3_rneg <= n3_rneg;
            r3_mag  <= n3_mag;
            r3_d    <= r2_mb;
            r3_p00  <= r2_ma[31:0]  * r2_mb[31:0];
            r3_p01  <= r2_ma[31:0]  * r2_mb[63:32];
            r3_p10  <= r2_ma[63:32] * r2_mb[31:0];
            r3_p11  <= r2_ma[63:32] * r2_mb[63:32];
            r3_num  <= ({{DATA_W{1'b0}}, r2_ma} << FRACTION_BITS)
                       + {{DATA_W{1'b0}}, (r2_mb >> 1)};

            r4_op   <= r3_op;
            r4_neg  <= r3_neg;
            r4_rneg <= r3_rneg;
            r4_mag  <= r3_mag;
            r4_d    <= r3_d;
            r4_num  <= r3_num;
            r4_prod <= {{DATA_W{1'b0}}, r3_p00}
                       + ({{DATA_W{1'b0}}, r3_p01} << 32)
                       + ({{DATA_W{1'b0}}, r3_p10} << 32)
                       + {r3_p11, {DATA_W{1'b0}}}
                       + {{DATA_W{1'b0}}, HALF};
        end
    end

    assign o_div = r5;

endmodule

FILE: src/fpra_div_stage.sv
// One registered stage of the restoring divider: DIV_STEPS quotient bits.
// Depends on fpra_pkg.
module fpra_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fpra_pkg::t_div i_div,
    output fpra_pkg::t_div o_div
);
    import fpra_pkg::*;

    t_div r_div, n_div;

    always_comb begin
        logic [DATA_W:0] rem2;
        n_div = i_div;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem2      = {n_div.rem, n_div.num[NUM_W-1]};
            n_div.num = n_div.num << 1;
            if (rem2 >= {1'b0, n_div.d}) begin
                rem2    = rem2 - {1'b0, n_div.d};
                n_div.q = {n_div.q[DATA_W-2:0], 1'b1};
            end else begin
                n_div.q = {n_div.q[DATA_W-2:0], 1'b0};
            end
            n_div.rem = rem2[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

FILE: src/fixed_point_rounding_alu.sv
// Top level of the signed Q-format fixed-point ALU.
// Depends on fpra_pkg, fpra_pre and fpra_div_stage.
//
// Usage:
//   Input channel i_valid/o_stall carries i_operation, i_operand_a, i_operand_b.
//   Output channel o_valid/i_stall carries o_result and o_divide_by_zero.
//   A transaction moves on a rising edge with valid high and stall low.
//   Operations: add, subtract, multiply, divide, round to integer, integer
//   to fixed; codes 6 and 7 give zero.
// Pipeline: every operation takes the same path (5 front stages, 64 divider stages
//   of two quotient bits each, one output register), so results stay in order.
// Throughput: one transaction per cycle while not stalled; the 128-bit restoring divide is
//   unrolled into the stage chain.
// Stall: the whole pipeline holds while the output register is full and
//   i_stall is high; o_stall is raised in exactly those cycles.
// Reset: synchronous, active low; clears all valid bits, nothing else.
module fixed_point_rounding_alu #(
    parameter int FRACTION_BITS = fpra_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_operation,
    input  logic [fpra_pkg::DATA_W-1:0] i_operand_a,
    input  logic [fpra_pkg::DATA_W-1:0] i_operand_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fpra_pkg::DATA_W-1:0] o_result,
    output logic                        o_divide_by_zero
);
    import fpra_pkg::*;

    logic              en;
    t_div              chain [DIV_STAGES+1];
    t_div              last;
    logic              r_valid;
    logic [DATA_W-1:0] r_result, n_result;
    logic              r_dz;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    fpra_pre #(.FRACTION_BITS(FRACTION_BITS)) u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_div       (chain[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        fpra_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (chain[g]),
            .o_div   (chain[g+1])
        );
    end

    assign last = chain[DIV_STAGES];

    always_comb begin
        if (!last.is_div) begin
            n_result = last.res;
        end else if (last.dz) begin
            n_result = '0;
        end else begin
            n_result = last.neg ? (~last.q + DATA_W'(1)) : last.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_result <= n_result;
            r_dz     <= last.is_div && last.dz;
        end
    end

    assign o_valid          = r_valid;
    assign o_result         = r_result;
    assign o_divide_by_zero = r_dz;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result == '0))
        else $error("divide by zero with nonzero result");
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without full stalled output");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
